// ===== sv/mpu_pkg.sv =====
// Shared types, widths and register codes of the multichannel phase unwrapper.
// Used by the top level; depends on nothing.
`default_nettype none

package mpu_pkg;

    localparam int SAMPLE_BITS          = 16;
    localparam int RESULT_BITS          = 32;
    localparam int CHANNEL_BITS         = 12;
    localparam int COUNT_BITS           = 13;
    localparam int THRESH_BITS          = 16;
    localparam int STEP_BITS            = 18;
    localparam int OUT_BITS             = 32;
    localparam int CFG_INDEX_BITS       = 8;
    localparam int CFG_DATA_BITS        = 32;
    localparam int EPOCH_BITS           = 8;
    localparam int DEFAULT_NUM_CHANNELS = 4096;

    localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = {EPOCH_BITS{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_UPPER_THRESHOLD = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOWER_THRESHOLD = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_WRAP_STEP       = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_BYPASS          = CFG_INDEX_BITS'(3);

    localparam logic signed [THRESH_BITS-1:0] UPPER_RESET = 16'sd16383;
    localparam logic signed [THRESH_BITS-1:0] LOWER_RESET = -16'sd16384;
    localparam logic [STEP_BITS-1:0]          STEP_RESET  = 18'd65536;

    typedef enum logic [0:0] {
        ST_SWEEP,
        ST_RUN
    } mpu_state_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [CHANNEL_BITS-1:0]       channel;
        logic [COUNT_BITS-1:0]         channel_count;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] unwrapped;
        logic [CHANNEL_BITS-1:0]    out_channel;
    } out_item_t;

    typedef struct packed {
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  value;
    } cfg_item_t;

    // One entry of the per-channel state memory. An entry whose epoch differs
    // from the current epoch reads as cleared.
    typedef struct packed {
        logic [EPOCH_BITS-1:0]         epoch;
        logic signed [SAMPLE_BITS-1:0] prev;
        logic [RESULT_BITS-1:0]        offset;
    } mem_entry_t;

endpackage

`default_nettype wire

// ===== sv/mpu_chan_if.sv =====
// Valid/ready channel carrying one payload item per handshake.
// The payload type comes from mpu_pkg at the point of instantiation.
`default_nettype none

interface mpu_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/mpu_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// A read of the address written in the same cycle returns the old contents.
`default_nettype none

module mpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/multichannel_phase_unwrapper_top.sv =====
// Top level of the multichannel phase unwrapper: pipeline, configuration and clearing.
// Depends on mpu_pkg, mpu_chan_if and mpu_ram.
//
//   Channel   Direction  Payload                                   Handshake
//   samples   in         sample, channel, channel_count            valid/ready
//   results   out        unwrapped, out_channel                    valid/ready
//   cfg       in         index, value                              valid/ready
//
// One item enters per cycle unless a stalled result or the clearing pass holds
// the input; its result passes the read of the channel's state entry, the
// update and write-back, then the final add, each registered. The single
// read-modify-write of the state RAM per item sets that rate. After reset the
// block clears every entry of the state RAM and takes no item meanwhile; the
// same pass runs whenever the clear epoch runs out, once every 2^EPOCH_BITS - 1
// channel count changes. A stalled result holds the whole pipeline; the output
// register lets it move on whenever the result in it is taken in the same cycle.
`default_nettype none

module multichannel_phase_unwrapper_top #(
    parameter int NUM_CHANNELS = mpu_pkg::DEFAULT_NUM_CHANNELS
) (
    input wire logic clk,
    input wire logic rst_n,
    mpu_chan_if.sink   samples,
    mpu_chan_if.source results,
    mpu_chan_if.sink   cfg
);

    import mpu_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_CHANNELS - 1);

    // Reduce a channel index to a state slot by subtracting shifted copies of
    // the state depth NUM_CHANNELS. Steps whose shifted depth exceeds the index
    // range drop out, so a depth of 2^CHANNEL_BITS or more costs nothing.
    function automatic logic [CHANNEL_BITS-1:0] slot_of(input logic [CHANNEL_BITS-1:0] c);
        logic [31:0] r;
        logic [31:0] m;
        r = 32'(c);
        for (int k = CHANNEL_BITS - 1; k >= 0; k--)
        begin
            m = 32'(NUM_CHANNELS) << k;
            if (m < (32'd1 << CHANNEL_BITS) && r >= m)
            begin
                r = r - m;
            end
        end
        return CHANNEL_BITS'(r);
    endfunction

    // Configuration registers. The port never stalls.
    logic signed [THRESH_BITS-1:0] upper_reg;
    logic signed [THRESH_BITS-1:0] lower_reg;
    logic [STEP_BITS-1:0]          step_reg;
    logic                          bypass_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg  <= UPPER_RESET;
            lower_reg  <= LOWER_RESET;
            step_reg   <= STEP_RESET;
            bypass_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                REG_UPPER_THRESHOLD: upper_reg  <= cfg.data.value[THRESH_BITS-1:0];
                REG_LOWER_THRESHOLD: lower_reg  <= cfg.data.value[THRESH_BITS-1:0];
                REG_WRAP_STEP:       step_reg   <= cfg.data.value[STEP_BITS-1:0];
                REG_BYPASS:          bypass_reg <= cfg.data.value[0];
                default:             ;
            endcase
        end
    end

    // Control state.
    mpu_state_t             state_reg, state_next;
    logic [AW-1:0]          sweep_addr_reg, sweep_addr_next;
    logic [EPOCH_BITS-1:0]  epoch_reg, epoch_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic                   sweeping;
    logic                   sweep_last;

    // Pipeline registers.
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [CHANNEL_BITS-1:0]       s1_chan_reg;
    logic [AW-1:0]                 s1_slot_reg;
    logic                          s1_bypass_reg;
    logic [EPOCH_BITS-1:0]         s1_epoch_reg;

    logic                          s2_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s2_sample_reg;
    logic [CHANNEL_BITS-1:0]       s2_chan_reg;
    logic [RESULT_BITS-1:0]        s2_offset_reg;
    logic                          s2_write_reg;
    logic [AW-1:0]                 s2_slot_reg;
    mem_entry_t                    s2_entry_reg;

    logic      out_valid_reg;
    out_item_t out_data_reg;

    // The whole pipeline moves whenever the output register is free or drains.
    logic adv;
    logic count_change;
    logic need_sweep;
    logic in_accept;
    logic [AW-1:0] in_slot;

    assign adv          = !out_valid_reg || results.ready;
    assign count_change = samples.data.channel_count != count_reg;
    assign need_sweep   = count_change && (epoch_reg == EPOCH_MAX);
    assign samples.ready = (state_reg == ST_RUN) && adv && !need_sweep;
    assign in_accept    = samples.valid && samples.ready;
    assign in_slot      = AW'(slot_of(samples.data.channel));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
        end
    end

    // The clearing pass waits until the item in the update stage has written
    // its entry, so that no stale write lands after the pass.
    always_comb
    begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        sweeping        = 1'b0;
        sweep_last      = 1'b0;
        unique case (state_reg)
            ST_SWEEP:
            begin
                sweeping        = 1'b1;
                sweep_addr_next = sweep_addr_reg + 1'b1;
                if (sweep_addr_reg == LAST_ADDR)
                begin
                    sweep_last      = 1'b1;
                    sweep_addr_next = '0;
                    state_next      = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (samples.valid && need_sweep && !s1_valid_reg)
                begin
                    state_next = ST_SWEEP;
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    // A change of channel count moves to a fresh epoch, which retires every
    // entry at once. The pass resets the epoch once it has tagged all entries.
    always_comb
    begin
        epoch_next = epoch_reg;
        if (sweep_last)
        begin
            epoch_next = '0;
        end
        else if (in_accept && count_change)
        begin
            epoch_next = epoch_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            epoch_reg <= epoch_next;
            if (in_accept)
            begin
                count_reg <= samples.data.channel_count;
            end
        end
    end

    // State RAM.
    logic       ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    mem_entry_t ram_wr_data;
    mem_entry_t ram_rd_data;

    mpu_ram #(
        .WIDTH ($bits(mem_entry_t)),
        .DEPTH (NUM_CHANNELS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (in_accept),
        .rd_addr (in_slot),
        .rd_data (ram_rd_data)
    );

    // Update stage. The item one stage ahead wrote at the same edge this item
    // read, so its entry is forwarded when the slots match.
    logic                          fwd;
    mem_entry_t                    raw_entry;
    logic                          live;
    logic signed [SAMPLE_BITS-1:0] prev;
    logic [RESULT_BITS-1:0]        offset;
    logic [RESULT_BITS-1:0]        step_ext;
    logic                          wrap_down;
    logic                          wrap_up;
    logic [RESULT_BITS-1:0]        new_offset;
    mem_entry_t                    upd_entry;

    always_comb
    begin
        fwd        = s2_valid_reg && s2_write_reg && (s2_slot_reg == s1_slot_reg);
        raw_entry  = fwd ? s2_entry_reg : ram_rd_data;
        live       = raw_entry.epoch == s1_epoch_reg;
        prev       = live ? raw_entry.prev : '0;
        offset     = live ? raw_entry.offset : '0;
        step_ext   = RESULT_BITS'(step_reg);
        wrap_down  = (s1_sample_reg > upper_reg) && (prev < lower_reg);
        wrap_up    = (s1_sample_reg < lower_reg) && (prev > upper_reg);
        if (wrap_down)
        begin
            new_offset = offset - step_ext;
        end
        else if (wrap_up)
        begin
            new_offset = offset + step_ext;
        end
        else
        begin
            new_offset = offset;
        end
        upd_entry.epoch  = s1_epoch_reg;
        upd_entry.prev   = s1_sample_reg;
        upd_entry.offset = new_offset;
    end

    assign ram_wr_en   = sweeping || (s1_valid_reg && adv && !s1_bypass_reg);
    assign ram_wr_addr = sweeping ? sweep_addr_reg : s1_slot_reg;
    assign ram_wr_data = sweeping ? mem_entry_t'('0) : upd_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_accept;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sample_reg <= samples.data.sample;
            s1_chan_reg   <= samples.data.channel;
            s1_slot_reg   <= in_slot;
            s1_bypass_reg <= bypass_reg;
            s1_epoch_reg  <= epoch_next;

            s2_sample_reg <= s1_sample_reg;
            s2_chan_reg   <= s1_chan_reg;
            s2_offset_reg <= s1_bypass_reg ? '0 : new_offset;
            s2_write_reg  <= !s1_bypass_reg;
            s2_slot_reg   <= s1_slot_reg;
            s2_entry_reg  <= upd_entry;

            out_data_reg.unwrapped   <= OUT_BITS'(s2_offset_reg + RESULT_BITS'(s2_sample_reg));
            out_data_reg.out_channel <= s2_chan_reg;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

`ifndef SYNTH
    // No item may enter while the clearing pass owns the write port.
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> !samples.ready)
        else $error("item accepted during clearing pass");

    // The pass only starts once the update stage is empty.
    a_sweep_stage_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> !s1_valid_reg)
        else $error("update stage busy during clearing pass");

    // A count change always moves to a fresh epoch.
    a_epoch_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && count_change |=> epoch_reg == EPOCH_BITS'($past(epoch_reg) + 1'b1))
        else $error("epoch did not advance on count change");

    // After the last entry of the pass, the epoch is zero and the block is back in the run state.
    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_last |=> epoch_reg == '0 && state_reg == ST_RUN)
        else $error("clearing pass ended in a wrong state");
`endif

endmodule

`default_nettype wire
